// ===== rtl/sensor_voltage_to_temperature_assert.svh =====
// Assertion macros shared by the checker file of the sensor voltage converter
`ifndef SENSOR_VOLTAGE_TO_TEMPERATURE_ASSERT_SVH
`define SENSOR_VOLTAGE_TO_TEMPERATURE_ASSERT_SVH

// check a property on every rising clk edge outside reset
`define SVT_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never holds
`define SVT_ASSERT_NEVER(label, cond, msg) \
  `SVT_ASSERT_CLK(label, !(cond), msg)

`endif

// ===== rtl/svt_pkg.sv =====
// Types, constants and breakpoint tables of the sensor voltage converter
package svt_pkg;

  localparam int STORED_ENTRIES = 21;
  localparam int IDX_W          = 5;
  localparam int VOLT_W         = 21;
  localparam int SLOPE_W        = 13;
  localparam int TEMP_W         = 16;
  localparam int QUO_W          = 16;
  localparam int DVD_W          = 28;
  localparam int SEG_W          = 9;
  localparam int PROD_W         = 23;
  localparam int MAG_W          = 21;

  localparam logic [VOLT_W-1:0] BP_UV [STORED_ENTRIES] = '{
    21'd1350441, 21'd1300593, 21'd1250398, 21'd1199884, 21'd1149070,
    21'd1097987, 21'd1046647, 21'd995050,  21'd943227,  21'd891178,
    21'd838882,  21'd786360,  21'd733608,  21'd680654,  21'd627490,
    21'd574117,  21'd520551,  21'd466760,  21'd412739,  21'd358164,
    21'd302785
  };

  localparam logic [SLOPE_W-1:0] SLOPE_UV [STORED_ENTRIES] = '{
    13'd4985, 13'd5020, 13'd5051, 13'd5081, 13'd5108,
    13'd5134, 13'd5160, 13'd5182, 13'd5205, 13'd5230,
    13'd5252, 13'd5275, 13'd5295, 13'd5316, 13'd5337,
    13'd5357, 13'd5379, 13'd5402, 13'd5458, 13'd5538,
    13'd5538
  };

  typedef struct packed {
    logic             done;
    logic             above;
    logic [IDX_W-1:0] idx;
  } srch_res_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_res_t;

  function automatic logic [VOLT_W-1:0] bp_at(input logic [IDX_W-1:0] i);
    logic [VOLT_W-1:0] r;
    r = '0;
    if (i < IDX_W'(STORED_ENTRIES)) begin
      r = BP_UV[i];
    end
    return r;
  endfunction

  function automatic logic [SLOPE_W-1:0] slope_at(input logic [IDX_W-1:0] i);
    logic [SLOPE_W-1:0] r;
    r = '0;
    if (i < IDX_W'(STORED_ENTRIES)) begin
      r = SLOPE_UV[i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sensor_voltage_to_temperature.sv =====
// Sensor voltage to temperature converter: sequencer and interpolation datapath
// One word is taken when start is high and busy is low; busy then stays high
// until the result word shows on the out_ ports for one cycle with out_valid,
// and a new word may be started in that same cycle. An in-range voltage passes
// through the table search (one comparator probe per cycle), the segment product
// and scaling, and the serial divider, which retires one quotient bit per cycle.
// A voltage above the first breakpoint skips the arithmetic and returns zero with
// out_above_range after the search.
// The receiver cannot stall: out_valid lasts exactly one cycle.
module sensor_voltage_to_temperature #(
  parameter int TABLE_ENTRIES = 21
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [svt_pkg::VOLT_W-1:0]        in_voltage_uv,
  output logic                              out_valid,
  output logic signed [svt_pkg::TEMP_W-1:0] out_temperature_centi,
  output logic                              out_above_range
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SRCH  = 5'b00010,
    ST_PROD  = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_DIV   = 5'b10000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [svt_pkg::VOLT_W-1:0]          volt_r, volt_nxt;
  logic [svt_pkg::IDX_W-1:0]           idx_r, idx_nxt;
  logic [svt_pkg::SLOPE_W-1:0]         slope_r, slope_nxt;
  logic signed [svt_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [svt_pkg::PROD_W-1:0]   diff_r, diff_nxt;
  logic [svt_pkg::DVD_W-1:0]           dvd_r, dvd_nxt;
  logic                                neg_r, neg_nxt;
  logic                                go_r, go_nxt;
  logic                                valid_r, valid_nxt;
  logic signed [svt_pkg::TEMP_W-1:0]   temp_r, temp_nxt;
  logic                                above_r, above_nxt;

  logic                                accept;
  svt_pkg::srch_res_t                  srch;
  svt_pkg::div_res_t                   divr;
  logic [7:0]                          idx10;
  logic signed [svt_pkg::SEG_W-1:0]    seg;
  logic signed [svt_pkg::PROD_W-1:0]   num;
  logic signed [svt_pkg::PROD_W-1:0]   num_abs;
  logic [svt_pkg::MAG_W-1:0]           mag;
  logic [svt_pkg::TEMP_W-1:0]          quo_neg;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  svt_search #(
    .NUM_ENTRIES(TABLE_ENTRIES)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (accept),
    .voltage_uv (volt_r),
    .res        (srch)
  );

  svt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go_r),
    .dividend (dvd_r),
    .divisor  (slope_r),
    .res      (divr)
  );

  assign idx10   = 8'({idx_r, 3'b000}) + 8'({idx_r, 1'b0});
  assign seg     = $signed({1'b0, idx10}) - 9'sd50;
  assign num     = prod_r + diff_r;
  assign num_abs = num[svt_pkg::PROD_W-1] ? -num : num;
  assign mag     = num_abs[svt_pkg::MAG_W-1:0];
  assign quo_neg = -divr.quo;

  always_comb begin
    state_nxt = state_r;
    volt_nxt  = volt_r;
    idx_nxt   = idx_r;
    slope_nxt = slope_r;
    prod_nxt  = prod_r;
    diff_nxt  = diff_r;
    dvd_nxt   = dvd_r;
    neg_nxt   = neg_r;
    go_nxt    = 1'b0;
    valid_nxt = 1'b0;
    temp_nxt  = temp_r;
    above_nxt = above_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          volt_nxt  = in_voltage_uv;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (srch.done) begin
          if (srch.above) begin
            temp_nxt  = '0;
            above_nxt = 1'b1;
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = srch.idx;
            state_nxt = ST_PROD;
          end
        end
      end
      ST_PROD: begin
        slope_nxt = svt_pkg::slope_at(idx_r);
        prod_nxt  = seg * $signed({1'b0, svt_pkg::slope_at(idx_r)});
        diff_nxt  = $signed({2'b00, svt_pkg::bp_at(idx_r)}) - $signed({2'b00, volt_r});
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        neg_nxt   = num[svt_pkg::PROD_W-1];
        dvd_nxt   = svt_pkg::DVD_W'(mag) * svt_pkg::DVD_W'(100);
        go_nxt    = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (divr.done) begin
          temp_nxt  = neg_r ? $signed(quo_neg) : $signed(divr.quo);
          above_nxt = 1'b0;
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      go_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      valid_r <= valid_nxt;
    end
    volt_r  <= volt_nxt;
    idx_r   <= idx_nxt;
    slope_r <= slope_nxt;
    prod_r  <= prod_nxt;
    diff_r  <= diff_nxt;
    dvd_r   <= dvd_nxt;
    neg_r   <= neg_nxt;
    temp_r  <= temp_nxt;
    above_r <= above_nxt;
  end

  assign out_valid             = valid_r;
  assign out_temperature_centi = temp_r;
  assign out_above_range       = above_r;

endmodule

// ===== rtl/svt_search.sv =====
// Binary search of the descending breakpoint table with one shared comparator
module svt_search #(
  parameter int NUM_ENTRIES = 21
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [svt_pkg::VOLT_W-1:0]     voltage_uv,
  output svt_pkg::srch_res_t             res
);

  localparam int USED = (NUM_ENTRIES > svt_pkg::STORED_ENTRIES) ?
                        svt_pkg::STORED_ENTRIES : NUM_ENTRIES;

  logic [svt_pkg::IDX_W-1:0] lo_r, lo_nxt;
  logic [svt_pkg::IDX_W-1:0] hi_r, hi_nxt;
  logic                      run_r, run_nxt;
  logic [svt_pkg::IDX_W:0]   sum;
  logic [svt_pkg::IDX_W-1:0] mid;
  logic                      ge;

  assign sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid = sum[svt_pkg::IDX_W:1];
  assign ge  = svt_pkg::bp_at(mid) >= voltage_uv;

  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    run_nxt = run_r;
    if (go) begin
      lo_nxt  = '0;
      hi_nxt  = svt_pkg::IDX_W'(USED);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (lo_r == hi_r) begin
        run_nxt = 1'b0;
      end else if (ge) begin
        lo_nxt = mid + 1'b1;
      end else begin
        hi_nxt = mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign res.done  = run_r && (lo_r == hi_r);
  assign res.above = (lo_r == '0);
  assign res.idx   = lo_r - 1'b1;

endmodule

// ===== rtl/svt_div.sv =====
// Restoring serial divider, one quotient bit per cycle
module svt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [svt_pkg::DVD_W-1:0]   dividend,
  input  logic [svt_pkg::SLOPE_W-1:0] divisor,
  output svt_pkg::div_res_t           res
);

  localparam int CNT_W = $clog2(svt_pkg::QUO_W + 1);

  logic [svt_pkg::SLOPE_W-1:0] rem_r, rem_nxt;
  logic [svt_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic [svt_pkg::SLOPE_W+1:0] trial;
  logic [svt_pkg::SLOPE_W-1:0] shifted;
  logic                        fits;

  assign trial   = {1'b0, rem_r, quo_r[svt_pkg::QUO_W-1]} - {2'b00, divisor};
  assign fits    = !trial[svt_pkg::SLOPE_W+1];
  assign shifted = {rem_r[svt_pkg::SLOPE_W-2:0], quo_r[svt_pkg::QUO_W-1]};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (go) begin
      rem_nxt = svt_pkg::SLOPE_W'(dividend[svt_pkg::DVD_W-1:svt_pkg::QUO_W]);
      quo_nxt = dividend[svt_pkg::QUO_W-1:0];
      cnt_nxt = CNT_W'(svt_pkg::QUO_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        rem_nxt = fits ? trial[svt_pkg::SLOPE_W-1:0] : shifted;
        quo_nxt = {quo_r[svt_pkg::QUO_W-2:0], fits};
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign res.done = run_r && (cnt_r == '0);
  assign res.quo  = quo_r;

endmodule

// ===== rtl/svt_checker.sv =====
// Port-level checker for the sensor voltage converter and its bind
`include "sensor_voltage_to_temperature_assert.svh"

module svt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic signed [svt_pkg::TEMP_W-1:0] out_temperature_centi,
  input logic                              out_above_range
);

  `SVT_ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `SVT_ASSERT_CLK(a_result_after_busy, out_valid |-> $past(busy), "result without a word in work")
  `SVT_ASSERT_CLK(a_single_strobe, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `SVT_ASSERT_NEVER(a_above_zero, out_valid && out_above_range && (out_temperature_centi != '0),
    "above-range result is not zero")
  `SVT_ASSERT_NEVER(a_temp_span, out_valid && !out_above_range &&
    ((out_temperature_centi < -16'sd5000) || (out_temperature_centi > 16'sd20500)),
    "temperature outside table span")

endmodule

bind sensor_voltage_to_temperature svt_checker u_svt_checker (.*);
